// File: hdl/ecmt_pkg.sv
// Shared types and constants for the entity component mask table.
// Holds table sizes, operation and status codes, and the request/response
// payload structs. No dependencies.
`default_nettype none

package ecmt_pkg;

    localparam int ENTITIES   = 1024;
    localparam int COMPONENTS = 32;
    localparam int ID_W       = $clog2(ENTITIES);
    localparam int CNT_W      = ID_W + 1;
    localparam int COMP_W     = $clog2(COMPONENTS);

    localparam logic [2:0] MODE_NEW    = 3'd0;
    localparam logic [2:0] MODE_FREE   = 3'd1;
    localparam logic [2:0] MODE_ADD    = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_HAS    = 3'd4;
    localparam logic [2:0] MODE_SCAN   = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic [2:0]            mode;
        logic [ID_W-1:0]       entity_id;
        logic [COMP_W-1:0]     component_index;
        logic [COMPONENTS-1:0] query_mask;
        logic [ID_W-1:0]       start_index;
    } req_item_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] found_id;
        logic            bit_answer;
    } rsp_item_t;

endpackage

`default_nettype wire

// File: hdl/entity_component_mask_table.sv
// Entity component mask table: entity alive marks and component bit masks
// kept in on-chip memory, plus a last-in first-out stack of freed ids.
// Each request carries one operation: new, free, add, remove, has or scan.
// Requests enter on req_valid/req_ready with a req_data payload; one
// response per request leaves on rsp_valid/rsp_ready with rsp_data.
// New, free, add, remove and has: the entry (or the stack top) is read at
// the request transfer, and S_EXEC then modifies, writes back and
// registers the response once the output register is free.
// Scan walks the table one entry per cycle through the same read port,
// from start_index up to the high-water mark, and answers with the first
// alive entry whose mask holds every query_mask bit, or with no-match
// status when none does.
// One request is in flight at a time; req_ready returns together with
// rsp_valid, even while that response still sits unclaimed in the output
// register, so no new request is taken while one is in S_EXEC or S_SCAN.
// When the receiver stalls, a finished request holds with its writes
// pending until the output register frees, so no state moves early.
// Reset clears the control state and the free and high-water counts; the
// memories are not cleared, since only entries below the high-water mark
// are ever used, and each is written when its id is first handed out.
`default_nettype none

module entity_component_mask_table (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    output logic                    req_ready,
    input  wire ecmt_pkg::req_item_t req_data,
    output logic                    rsp_valid,
    input  wire                     rsp_ready,
    output ecmt_pkg::rsp_item_t     rsp_data
);
    import ecmt_pkg::*;

    typedef struct packed {
        logic                  alive;
        logic [COMPONENTS-1:0] mask;
    } entry_t;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_t;

    state_t     state_reg, state_next;
    req_item_t  item_reg, item_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] high_water_reg, high_water_next;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_item_t  rsp_reg, rsp_next;

    entry_t          tab_mem [ENTITIES];
    logic [ID_W-1:0] stk_mem [ENTITIES];
    entry_t          tab_rd_reg;
    logic [ID_W-1:0] stk_rd_reg;

    logic [ID_W-1:0]  tab_raddr;
    logic             tab_we;
    logic [ID_W-1:0]  tab_waddr;
    entry_t           tab_wdata;
    logic             stk_we;
    logic [ID_W-1:0]  stk_waddr;
    logic [ID_W-1:0]  stk_raddr;
    logic [CNT_W-1:0] fc_dec;
    logic [CNT_W-1:0] idx_inc;
    logic             out_free;
    logic             id_used;
    logic             finish;
    rsp_item_t        res;
    logic [ID_W-1:0]  new_id;
    logic             new_got;
    logic [COMPONENTS-1:0] cbit;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign fc_dec    = free_count_reg - CNT_W'(1);
    assign stk_raddr = fc_dec[ID_W-1:0];
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign id_used   = {1'b0, item_reg.entity_id} < high_water_reg;
    assign cbit      = COMPONENTS'(1) << item_reg.component_index;

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        tab_rd_reg <= tab_mem[tab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= item_reg.entity_id;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        tab_raddr       = item_reg.entity_id;
        tab_we          = 1'b0;
        tab_waddr       = item_reg.entity_id;
        tab_wdata       = tab_rd_reg;
        stk_we          = 1'b0;
        stk_waddr       = free_count_reg[ID_W-1:0];
        res             = '0;
        finish          = 1'b0;
        new_id          = high_water_reg[ID_W-1:0];
        new_got         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req_data;
                    idx_next  = {1'b0, req_data.start_index};
                    if (req_data.mode == MODE_SCAN)
                    begin
                        tab_raddr  = req_data.start_index;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        tab_raddr  = req_data.entity_id;
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                finish = 1'b1;
                case (item_reg.mode)
                    MODE_NEW:
                    begin
                        if (free_count_reg != '0)
                        begin
                            new_id  = stk_rd_reg;
                            new_got = 1'b1;
                            if (out_free)
                            begin
                                free_count_next = fc_dec;
                            end
                        end
                        else if (high_water_reg < CNT_W'(ENTITIES))
                        begin
                            new_got = 1'b1;
                            if (out_free)
                            begin
                                high_water_next = high_water_reg + CNT_W'(1);
                            end
                        end
                        if (new_got)
                        begin
                            res.found_id = new_id;
                            tab_we       = out_free;
                            tab_waddr    = new_id;
                            tab_wdata    = '{alive: 1'b1, mask: '0};
                        end
                        else
                        begin
                            res.status = ST_FULL;
                        end
                    end
                    MODE_FREE:
                    begin
                        if (id_used && tab_rd_reg.alive &&
                            free_count_reg < CNT_W'(ENTITIES) && out_free)
                        begin
                            tab_we          = 1'b1;
                            tab_wdata.alive = 1'b0;
                            stk_we          = 1'b1;
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                    end
                    MODE_ADD:
                    begin
                        tab_we         = id_used && out_free;
                        tab_wdata.mask = tab_rd_reg.mask | cbit;
                    end
                    MODE_REMOVE:
                    begin
                        tab_we         = id_used && out_free;
                        tab_wdata.mask = tab_rd_reg.mask & ~cbit;
                    end
                    MODE_HAS:
                    begin
                        res.bit_answer = id_used &&
                                         tab_rd_reg.mask[item_reg.component_index];
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
            end

            S_SCAN:
            begin
                // data in tab_rd_reg belongs to idx_reg
                tab_raddr = idx_reg[ID_W-1:0];
                if (idx_reg >= high_water_reg)
                begin
                    finish     = 1'b1;
                    res.status = ST_NOMATCH;
                end
                else if (tab_rd_reg.alive &&
                         ((tab_rd_reg.mask & item_reg.query_mask) == item_reg.query_mask))
                begin
                    finish       = 1'b1;
                    res.found_id = idx_reg[ID_W-1:0];
                end
                else
                begin
                    idx_next  = idx_inc;
                    tab_raddr = idx_inc[ID_W-1:0];
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish && out_free)
        begin
            rsp_next       = res;
            rsp_valid_next = 1'b1;
            state_next     = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            high_water_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        rsp_reg  <= rsp_next;
    end

    // every freed id was handed out once, so the stack never outgrows it
    a_free_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= high_water_reg)
        else $error("free count above high water");

    a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        high_water_reg <= CNT_W'(ENTITIES))
        else $error("high water beyond table size");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg != S_IDLE)
        else $error("request transfer did not start work");

    a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_FULL |->
            high_water_reg == CNT_W'(ENTITIES) && free_count_reg == '0)
        else $error("full reported while ids remain");

endmodule

`default_nettype wire
